// ===== rtl/core/bpa_pkg.sv =====
// bpa_pkg: shared types, codes and sizes for the buddy page allocator
// no dependencies; used by the interfaces and every module of the block
package bpa_pkg;

    localparam int PAGE_CAP      = 256;
    localparam int DEF_MAX_PAGES = 256;
    localparam int PAGES_W       = 9;
    localparam int IDX_W         = 8;
    localparam int ORDER_W       = 4;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 3;
    localparam int WORD_W        = 16;
    localparam int WORD_SH       = 4;
    localparam int WIDX_W        = IDX_W - WORD_SH;
    localparam int CNT_W         = WIDX_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC,
        OP_CLAIM,
        OP_FREE,
        OP_QUERY
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE,
        ST_ORDER,
        ST_NOFREE,
        ST_BUSY,
        ST_RANGE
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_EX,
        S_FILL,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic rd;
        logic ex;
        logic fill;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic err;
        logic fill_now;
        logic go_fill;
        logic go_done;
        logic fill_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/bpa_ifs.sv =====
// bpa_req_if / bpa_rsp_if: valid-ready channels for requests and results
// depends on bpa_pkg for the field widths
interface bpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::OP_W-1:0]      opcode;
    logic [bpa_pkg::ORDER_W-1:0]   order;
    logic [bpa_pkg::IDX_W-1:0]     block_index;

    modport source (output valid, opcode, order, block_index, input ready);
    modport sink   (input valid, opcode, order, block_index, output ready);
endinterface

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::STATUS_W-1:0]  status;
    logic [bpa_pkg::IDX_W-1:0]     granted_index;
    logic                          page_free;

    modport source (output valid, status, granted_index, page_free, input ready);
    modport sink   (input valid, status, granted_index, page_free, output ready);
endinterface

// ===== rtl/core/bpa_ctrl.sv =====
// bpa_ctrl: request sequencer of the buddy page allocator
// depends on bpa_pkg; drives bpa_dp through t_cmd and reads t_sts
module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bpa_pkg::t_sts i_sts,
    output bpa_pkg::t_cmd o_cmd
);
    import bpa_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                priority if (i_sts.err) n_state = S_DONE;
                else if (i_sts.fill_now) n_state = S_FILL;
                else n_state = S_RD;
            end
            S_RD: n_state = S_EX;
            S_EX: begin
                priority if (i_sts.go_done) n_state = S_DONE;
                else if (i_sts.go_fill) n_state = S_FILL;
                else n_state = S_RD;
            end
            S_FILL: begin
                if (i_sts.fill_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_DECODE: o_cmd.decode = 1'b1;
            S_RD:     o_cmd.rd     = 1'b1;
            S_EX:     o_cmd.ex     = 1'b1;
            S_FILL:   o_cmd.fill   = 1'b1;
            S_DONE:   o_cmd.emit   = i_sts.out_free;
            default:  o_cmd        = '0;
        endcase
    end

endmodule

// ===== rtl/core/bpa_dp.sv =====
// bpa_dp: page bitmap memory, request registers and word scan datapath
// depends on bpa_pkg; sequenced by bpa_ctrl
module bpa_dp #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bpa_pkg::PAGES_W-1:0]  i_cfg_wdata,
    input  logic [bpa_pkg::OP_W-1:0]     i_opcode,
    input  logic [bpa_pkg::ORDER_W-1:0]  i_order,
    input  logic [bpa_pkg::IDX_W-1:0]    i_block_index,
    input  bpa_pkg::t_cmd                i_cmd,
    output bpa_pkg::t_sts                o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [bpa_pkg::STATUS_W-1:0] o_status,
    output logic [bpa_pkg::IDX_W-1:0]    o_granted_index,
    output logic                         o_page_free
);
    import bpa_pkg::*;

    localparam int CAP   = (MAX_PAGES < PAGE_CAP) ? MAX_PAGES : PAGE_CAP;
    localparam int WORDS = (CAP + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [PAGES_W-1:0] CAP_P  = PAGES_W'(CAP);
    localparam logic [WIDX_W-1:0]  LAST_W = WIDX_W'(WORDS - 1);

    // ones over the pages of one block of order up to WORD_SH
    function automatic logic [WORD_W-1:0] chunk_mask(input logic [ORDER_W-1:0] ord);
        logic [WORD_W:0] m;
        m = (WORD_W+1)'((WORD_W+1)'(1) << (5'(1) << ord[2:0])) - (WORD_W+1)'(1);
        return m[WORD_W-1:0];
    endfunction

    // configuration and request registers
    logic [PAGES_W-1:0] r_pages;
    t_op                r_op;
    logic [ORDER_W-1:0] r_order;
    logic [IDX_W-1:0]   r_idx;
    logic [WIDX_W-1:0]  r_w;
    logic [CNT_W-1:0]   r_cnt;
    logic [WORD_W-1:0]  r_mask;
    logic               r_clean;
    t_status            r_status;
    logic [IDX_W-1:0]   r_granted;
    logic               r_pfree;
    logic               r_out_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [IDX_W-1:0]   r_o_granted;
    logic               r_o_pfree;

    // bitmap memory, sixteen pages a word, with a valid bit per word
    logic [WORD_W-1:0]  mem [WORDS];
    logic [WORDS-1:0]   r_vld;
    logic [WORD_W-1:0]  r_rdata;
    logic               r_rvalid;

    // decode of the held request
    logic [PAGES_W-1:0] len;
    logic [22:0]        start_wide;
    logic [IDX_W-1:0]   page_start;
    logic               full;
    logic [ORDER_W-1:0] nl;
    logic [CNT_W-1:0]   nwords;
    logic [WIDX_W-1:0]  posmask;
    logic [WORD_W-1:0]  cm;
    t_status            dec_status;

    assign len        = r_pages >> r_order;
    assign start_wide = 23'(r_idx) << r_order;
    assign page_start = start_wide[IDX_W-1:0];
    assign full       = (r_order > ORDER_W'(WORD_SH));
    assign nl         = r_order - ORDER_W'(WORD_SH);
    assign nwords     = full ? CNT_W'(CNT_W'(1) << nl[2:0]) : CNT_W'(1);
    assign posmask    = WIDX_W'(nwords - CNT_W'(1));
    assign cm         = chunk_mask(r_order);

    always_comb begin
        dec_status = ST_DONE;
        priority if (r_op == OP_QUERY) begin
            if ({1'b0, r_idx} >= r_pages) dec_status = ST_RANGE;
        end else if (len == '0) begin
            dec_status = ST_ORDER;
        end else if (r_op != OP_ALLOC && {1'b0, r_idx} >= len) begin
            dec_status = ST_RANGE;
        end
    end

    // word just read, never written words read as free
    logic [WORD_W-1:0] d;
    assign d = r_rvalid ? r_rdata : '0;

    // lowest free aligned chunk within the word
    logic              found;
    logic [WIDX_W-1:0] found_pos;
    logic [IDX_W-1:0]  found_blk;
    logic [WIDX_W-1:0] low_mask;
    logic [WIDX_W:0]   low_wide;

    // a chunk start has its low order bits clear
    assign low_wide = (WIDX_W+1)'((WIDX_W+1)'(1) << r_order[2:0]) - (WIDX_W+1)'(1);
    assign low_mask = low_wide[WIDX_W-1:0];

    always_comb begin
        logic [WIDX_W-1:0] jj;
        logic [IDX_W-1:0]  blk;
        found     = 1'b0;
        found_pos = '0;
        found_blk = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            jj  = WIDX_W'(j);
            blk = {r_w, jj} >> r_order;
            if ((jj & low_mask) == '0 && ((d >> j) & cm) == '0 && {1'b0, blk} < len) begin
                found     = 1'b1;
                found_pos = jj;
                found_blk = blk;
            end
        end
    end

    // block scan over whole words
    logic [WIDX_W-1:0] pos;
    logic              clean;
    logic [WIDX_W-1:0] blkf;

    assign pos   = r_w & posmask;
    assign clean = ((pos == '0) | r_clean) & (d == '0);
    assign blkf  = r_w >> nl[2:0];

    // outcome of one examined word
    logic              ex_done, ex_fill, ex_we;
    logic [WORD_W-1:0] ex_wdata;
    t_status           ex_status;
    logic [IDX_W-1:0]  ex_granted;
    logic              ex_pfree;
    logic [WIDX_W-1:0] ex_w;
    logic [CNT_W-1:0]  ex_cnt;

    always_comb begin
        ex_done    = 1'b0;
        ex_fill    = 1'b0;
        ex_we      = 1'b0;
        ex_wdata   = d;
        ex_status  = r_status;
        ex_granted = r_granted;
        ex_pfree   = r_pfree;
        ex_w       = r_w + WIDX_W'(1);
        ex_cnt     = r_cnt - CNT_W'(1);
        unique case (r_op)
            OP_QUERY: begin
                ex_pfree = ~|(d & r_mask);
                ex_done  = 1'b1;
            end
            OP_CLAIM: begin
                priority if (|(d & r_mask)) begin
                    ex_status = ST_BUSY;
                    ex_done   = 1'b1;
                end else if (!full) begin
                    ex_we    = 1'b1;
                    ex_wdata = d | r_mask;
                    ex_done  = 1'b1;
                end else if (r_cnt == CNT_W'(1)) begin
                    ex_fill = 1'b1;
                    ex_w    = page_start[IDX_W-1:WORD_SH];
                    ex_cnt  = nwords;
                end
            end
            OP_FREE: begin
                ex_we    = 1'b1;
                ex_wdata = d & ~r_mask;
                ex_done  = 1'b1;
            end
            OP_ALLOC: begin
                if (!full) begin
                    priority if (found) begin
                        ex_we      = 1'b1;
                        ex_wdata   = d | (cm << found_pos);
                        ex_granted = found_blk;
                        ex_done    = 1'b1;
                    end else if (r_w == LAST_W) begin
                        ex_status = ST_NOFREE;
                        ex_done   = 1'b1;
                    end
                end else begin
                    priority if (pos == posmask && clean && {5'b0, blkf} < len) begin
                        ex_granted = IDX_W'(blkf);
                        ex_fill    = 1'b1;
                        ex_w       = r_w & ~posmask;
                        ex_cnt     = nwords;
                    end else if (r_w == LAST_W) begin
                        ex_status = ST_NOFREE;
                        ex_done   = 1'b1;
                    end
                end
            end
            default: ex_done = 1'b1;
        endcase
    end

    // memory write selection
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     addr;

    assign addr      = r_w[AW-1:0];
    assign mem_we    = (i_cmd.ex & ex_we) | i_cmd.fill;
    assign mem_wdata = i_cmd.fill ? ((r_op == OP_FREE) ? '0 : '1) : ex_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[addr] <= mem_wdata;
        if (i_cmd.rd) begin
            r_rdata  <= mem[addr];
            r_rvalid <= r_vld[addr];
        end
    end

    // word valid bits, cleared by reset and by a page count write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[addr] <= 1'b1;
        end
    end

    // page count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages <= CAP_P;
        end else if (i_cfg_we) begin
            priority if (i_cfg_wdata > CAP_P) r_pages <= CAP_P;
            else if (i_cfg_wdata == '0) r_pages <= PAGES_W'(1);
            else r_pages <= i_cfg_wdata;
        end
    end

    // request and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_opcode);
            r_order <= i_order;
            r_idx   <= i_block_index;
        end
        if (i_cmd.decode) begin
            r_status  <= dec_status;
            r_granted <= '0;
            r_pfree   <= 1'b0;
            r_clean   <= 1'b1;
            r_cnt     <= nwords;
            priority if (r_op == OP_ALLOC) r_w <= '0;
            else if (r_op == OP_QUERY) r_w <= r_idx[IDX_W-1:WORD_SH];
            else r_w <= page_start[IDX_W-1:WORD_SH];
            priority if (r_op == OP_QUERY) r_mask <= WORD_W'(1) << r_idx[WORD_SH-1:0];
            else if (full) r_mask <= '1;
            else r_mask <= cm << page_start[WORD_SH-1:0];
        end
        if (i_cmd.ex) begin
            r_status  <= ex_status;
            r_granted <= ex_granted;
            r_pfree   <= ex_pfree;
            r_clean   <= clean;
            r_w       <= ex_w;
            r_cnt     <= ex_cnt;
        end
        if (i_cmd.fill) begin
            r_w   <= r_w + WIDX_W'(1);
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status  <= r_status;
            r_o_granted <= r_granted;
            r_o_pfree   <= r_pfree;
        end
    end

    // status to controller
    always_comb begin
        o_sts.err       = (dec_status != ST_DONE);
        o_sts.fill_now  = (r_op == OP_FREE) && full;
        o_sts.go_fill   = ex_fill;
        o_sts.go_done   = ex_done;
        o_sts.fill_last = (r_cnt == CNT_W'(1));
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_granted_index = r_o_granted;
    assign o_page_free     = r_o_pfree;

endmodule

// ===== rtl/core/buddy_page_allocator.sv =====
// buddy_page_allocator: top level, joins the sequencer and the bitmap datapath
// depends on bpa_pkg, bpa_ifs, bpa_ctrl and bpa_dp
//
//  port      dir  transfer   payload
//  i_req     in   valid/rdy  opcode, order, block_index
//  o_rsp     out  valid/rdy  status, granted_index, page_free
//  i_cfg_*   in   we only    pages_in_use (9 bits)
//
// a query, or a claim or free of a block of up to 16 pages, reads and examines
// one word; a larger claim reads and examines its words and then writes them,
// a larger free writes its words, and an allocate reads and examines words in turn.
// the bitmap memory has a single port and holds 16 pages per word.
// reset and a page count write clear the map at once through per-word valid bits.
// a new request is taken while the previous result waits in the output register.
module buddy_page_allocator #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bpa_pkg::PAGES_W-1:0] i_cfg_wdata,
    bpa_req_if.sink                     i_req,
    bpa_rsp_if.source                   o_rsp
);
    import bpa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // request sequencer
    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // bitmap datapath
    bpa_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_req.opcode),
        .i_order         (i_req.order),
        .i_block_index   (i_req.block_index),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_granted_index (o_rsp.granted_index),
        .o_page_free     (o_rsp.page_free)
    );

endmodule

// ===== test/buddy_page_allocator_test.sv =====
// buddy_page_allocator_test: self-checking bench for the buddy page allocator
// depends on bpa_pkg, bpa_ifs and the buddy_page_allocator rtl
module buddy_page_allocator_test;
    import bpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_ITEMS   = 1330;

    typedef struct packed {
        t_op             opcode;
        logic [3:0]      order;
        logic [7:0]      block_index;
    } t_request;

    typedef struct packed {
        t_status         status;
        logic [7:0]      granted_index;
        logic            page_free;
    } t_outcome;

    // directed row: request plus an optional typed-in answer
    typedef struct {
        t_request req;
        logic     fixed;
        t_outcome want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [PAGES_W-1:0] i_cfg_wdata;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    buddy_page_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    // predictor state
    int   pages;
    int   levels;
    bit   occ [0:12][0:255];

    t_outcome outcome_queue [$];
    t_outcome override_queue [$];
    bit       override_flag [$];
    int       error_count;
    int       idle_cycles;
    bit       hold_rsp;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int level_len(int lvl);
        return pages >> lvl;
    endfunction

    function automatic void set_pages(logic [PAGES_W-1:0] value);
        int p;
        p = value;
        if (p > PAGE_CAP) p = PAGE_CAP;
        if (p == 0) p = 1;
        pages  = p;
        levels = 0;
        while (levels < 13 && (p >> levels) != 0) levels++;
        for (int l = 0; l < 13; l++)
            for (int b = 0; b < 256; b++) occ[l][b] = 1'b0;
    endfunction

    function automatic void occupy(int lvl, int blk);
        for (int d = 0; d < lvl; d++)
            for (int j = 0; j < (1 << (lvl - d)); j++)
                occ[d][(blk << (lvl - d)) + j] = 1'b1;
        for (int i = lvl; i < levels; i++)
            if ((blk >> (i - lvl)) < level_len(i)) occ[i][blk >> (i - lvl)] = 1'b1;
    endfunction

    function automatic void release_tree(int lvl, int blk);
        int parent;
        for (int d = 0; d <= lvl; d++)
            for (int j = 0; j < (1 << (lvl - d)); j++)
                occ[d][(blk << (lvl - d)) + j] = 1'b0;
        while (lvl + 1 < levels) begin
            parent = blk >> 1;
            if (parent >= level_len(lvl + 1)) return;
            if (occ[lvl][parent << 1] || occ[lvl][(parent << 1) + 1]) return;
            occ[lvl + 1][parent] = 1'b0;
            lvl++;
            blk = parent;
        end
    endfunction

    // works out the result of one request and updates the map
    function automatic t_outcome allocator_result(t_request r);
        t_outcome o;
        int ord, idx, len;
        o = '{status: ST_DONE, granted_index: 8'd0, page_free: 1'b0};
        ord = r.order;
        idx = r.block_index;
        if (r.opcode == OP_QUERY) begin
            if (idx >= pages) o.status = ST_RANGE;
            else o.page_free = !occ[0][idx];
        end else if (ord >= levels) begin
            o.status = ST_ORDER;
        end else begin
            len = level_len(ord);
            if (r.opcode == OP_ALLOC) begin
                o.status = ST_NOFREE;
                for (int k = 0; k < len; k++)
                    if (!occ[ord][k]) begin
                        occupy(ord, k);
                        o.granted_index = 8'(k);
                        o.status = ST_DONE;
                        break;
                    end
            end else if (idx >= len) begin
                o.status = ST_RANGE;
            end else if (r.opcode == OP_CLAIM) begin
                if (occ[ord][idx]) o.status = ST_BUSY;
                else occupy(ord, idx);
            end else begin
                release_tree(ord, idx);
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int gap_length();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        return $urandom_range(0, 3);
    endfunction

    // one request transfer, predicted at acceptance; valid stays up for the caller
    task automatic send_request(t_request r, bit fixed, t_outcome want);
        t_outcome pred;
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= r.opcode;
        req_ch.order       <= r.order;
        req_ch.block_index <= r.block_index;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pred = allocator_result(r);
        outcome_queue.push_back(pred);
        override_flag.push_back(fixed);
        override_queue.push_back(want);
    endtask

    task automatic send_with_gap(t_request r, bit fixed, t_outcome want);
        int g;
        g = gap_length();
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        send_request(r, fixed, want);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (outcome_queue.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pages(logic [PAGES_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_pages(value);
    endtask

    function automatic t_request random_request();
        t_request r;
        int kind;
        kind = $urandom_range(0, 9);
        r.opcode = t_op'($urandom_range(0, 3));
        if (kind < 8 && levels > 0) r.order = 4'($urandom_range(0, levels - 1));
        else r.order = 4'($urandom_range(0, 15));
        if (kind < 7 && r.opcode != OP_QUERY)
            r.block_index = 8'($urandom_range(0, (pages >> r.order) > 0 ?
                                                 (pages >> r.order) - 1 : 0));
        else if (kind < 7)
            r.block_index = 8'($urandom_range(0, pages - 1));
        else
            r.block_index = 8'($urandom_range(0, 255));
        // extra allocations keep the map filling
        if (kind == 0) r.opcode = OP_ALLOC;
        return r;
    endfunction

    // result side: stalls and checks
    initial begin
        t_outcome exp_o;
        t_outcome got;
        int       stall_len;
        rsp_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall_len = 0;
            if ($urandom_range(0, 2) == 0) stall_len = gap_length();
            if (hold_rsp || stall_len > 0) begin
                rsp_ch.ready <= 1'b0;
                while (hold_rsp) @(posedge i_clk);
                repeat (stall_len) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.status        = t_status'(rsp_ch.status);
                got.granted_index = rsp_ch.granted_index;
                got.page_free     = rsp_ch.page_free;
                if (outcome_queue.size() == 0) begin
                    report_mismatch("unexpected result, status", got.status, 0);
                end else begin
                    exp_o = outcome_queue.pop_front();
                    if (override_flag.pop_front()) exp_o = override_queue.pop_front();
                    else void'(override_queue.pop_front());
                    if (got.status !== exp_o.status)
                        report_mismatch("status", got.status, exp_o.status);
                    if (got.granted_index !== exp_o.granted_index)
                        report_mismatch("granted_index", got.granted_index,
                                        exp_o.granted_index);
                    if (got.page_free !== exp_o.page_free)
                        report_mismatch("page_free", got.page_free, exp_o.page_free);
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("buddy_page_allocator_test: errors");
                $finish;
            end
        end
    end

    // long receiver hold-off, counted here while the sender keeps offering
    initial begin
        hold_rsp = 1'b0;
        @(posedge i_rst_n);
        repeat (3000) @(posedge i_clk);
        hold_rsp = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rsp = 1'b0;
    end

    // stimulus
    initial begin
        t_row     rows [$];
        t_row     row;
        t_outcome none;
        logic [PAGES_W-1:0] settings [6];
        none = '{status: ST_DONE, granted_index: 8'd0, page_free: 1'b0};
        settings = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd13, 9'd100};
        error_count = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_ALLOC;
        req_ch.order = '0;
        req_ch.block_index = '0;
        set_pages(9'd256);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        rows.push_back('{'{OP_QUERY, 4'd0, 8'd0}, 1, '{ST_DONE, 8'd0, 1'b1}});
        rows.push_back('{'{OP_QUERY, 4'd15, 8'd255}, 1, '{ST_DONE, 8'd0, 1'b1}});
        rows.push_back('{'{OP_ALLOC, 4'd9, 8'd0}, 1, '{ST_ORDER, 8'd0, 1'b0}});
        rows.push_back('{'{OP_CLAIM, 4'd15, 8'd0}, 1, '{ST_ORDER, 8'd0, 1'b0}});
        rows.push_back('{'{OP_FREE, 4'd12, 8'd0}, 1, '{ST_ORDER, 8'd0, 1'b0}});
        rows.push_back('{'{OP_CLAIM, 4'd1, 8'd128}, 1, '{ST_RANGE, 8'd0, 1'b0}});
        rows.push_back('{'{OP_FREE, 4'd8, 8'd1}, 1, '{ST_RANGE, 8'd0, 1'b0}});
        rows.push_back('{'{OP_ALLOC, 4'd0, 8'd0}, 1, '{ST_DONE, 8'd0, 1'b0}});
        rows.push_back('{'{OP_ALLOC, 4'd0, 8'd0}, 1, '{ST_DONE, 8'd1, 1'b0}});
        rows.push_back('{'{OP_CLAIM, 4'd0, 8'd255}, 1, '{ST_DONE, 8'd0, 1'b0}});
        rows.push_back('{'{OP_CLAIM, 4'd0, 8'd255}, 1, '{ST_BUSY, 8'd0, 1'b0}});
        rows.push_back('{'{OP_QUERY, 4'd0, 8'd255}, 1, '{ST_DONE, 8'd0, 1'b0}});
        rows.push_back('{'{OP_ALLOC, 4'd8, 8'd0}, 1, '{ST_NOFREE, 8'd0, 1'b0}});
        rows.push_back('{'{OP_FREE, 4'd0, 8'd255}, 0, none});
        rows.push_back('{'{OP_FREE, 4'd0, 8'd255}, 0, none});
        rows.push_back('{'{OP_ALLOC, 4'd4, 8'd0}, 0, none});
        rows.push_back('{'{OP_CLAIM, 4'd7, 8'd1}, 0, none});
        rows.push_back('{'{OP_FREE, 4'd8, 8'd0}, 0, none});
        rows.push_back('{'{OP_ALLOC, 4'd8, 8'd0}, 1, '{ST_DONE, 8'd0, 1'b0}});
        rows.push_back('{'{OP_FREE, 4'd3, 8'd31}, 0, none});
        rows.push_back('{'{OP_QUERY, 4'd5, 8'd250}, 0, none});
        foreach (rows[i]) begin
            row = rows[i];
            send_with_gap(row.req, row.fixed, row.want);
        end

        // random phases over several page counts
        foreach (settings[s]) begin
            write_pages(settings[s]);
            if (s == 5) begin
                // odd level lengths: directed merge climb at the edge
                send_request('{OP_CLAIM, 4'd5, 8'd2}, 0, none);
                send_request('{OP_FREE, 4'd5, 8'd2}, 0, none);
            end
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                if (n % 60 == 59 && outcome_queue.size() != 0) begin
                    // sender pauses until all results are back
                    req_ch.valid <= 1'b0;
                    while (outcome_queue.size() != 0) @(posedge i_clk);
                end
                if (n % 200 < 80) send_request(random_request(), 0, none);
                else send_with_gap(random_request(), 0, none);
            end
        end
        write_pages(9'd256);
        send_request('{OP_ALLOC, 4'd8, 8'd0}, 1, '{ST_DONE, 8'd0, 1'b0});

        drain();
        if (error_count == 0) begin
            $display("buddy_page_allocator_test: clean");
        end else begin
            $display("buddy_page_allocator_test: errors");
        end
        $finish;
    end
endmodule
